### rtl/pnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnd_pkg
// Shared constants for the 2D gradient noise pipeline.
// ----------------------------------------------------------------------------
package pnd_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ANGLE_BITS = 10;

  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;

  localparam logic [16:0] SIN_C1 = 17'd102944;
  localparam logic [15:0] SIN_C3 = 16'd42177;
  localparam logic [12:0] SIN_C5 = 13'd4769;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Corner pipeline: dot product is registered in stage 11 (split is stage 1).
  localparam int unsigned OFS_DELAY  = 8;
  localparam int unsigned FRAC_DELAY = 9;
  localparam int unsigned WY_DELAY   = 4;
  localparam int unsigned PIPE_DEPTH = 17;

endpackage

### rtl/pnd_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnd_corner
// Hashes one lattice corner, looks up its unit gradient by a polynomial
// sine and forms the dot product with the offset vector. Ten stages.
// ----------------------------------------------------------------------------
module pnd_corner import pnd_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        cx_i,
  input  logic [31:0]        cy_i,
  input  logic signed [16:0] dx_i,
  input  logic signed [16:0] dy_i,
  output logic signed [34:0] dot_o
);

  localparam int unsigned RBITS = ANGLE_BITS - 2;
  localparam int unsigned ZSH   = 16 - RBITS;

  logic [31:0] a1_q, cy2_q, a1b_q, b_q, h_q;
  logic [31:0] b_d, h_d;

  logic [ANGLE_BITS-1:0] idx;
  logic [RBITS-1:0]      r;
  logic [16:0]           z, zc;

  logic [1:0]  quad_q [4];
  logic [16:0] zs5_q, zc5_q, zs6_q, zc6_q, zs7_q, zc7_q;
  logic [16:0] z2s_q, z2c_q, z2s6_q, z2c6_q;
  logic [15:0] ts_q, tc_q;
  logic [16:0] us_q, uc_q;
  logic [15:0] s_q, c_q;
  logic [17:0] ws, wc;
  logic [15:0] s_d, c_d;

  logic signed [16:0] ofx_q [OFS_DELAY];
  logic signed [16:0] ofy_q [OFS_DELAY];

  logic signed [16:0] s17, c17, gx_d, gy_d, gx_q, gy_q;
  logic signed [33:0] px_q, py_q;

  // hash
  assign b_d = 32'((cy2_q ^ {a1_q[15:0], a1_q[31:16]}) * HASH_M2);
  assign h_d = 32'((a1b_q ^ {b_q[15:0], b_q[31:16]}) * HASH_M3);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= 32'(cx_i * HASH_M1);
      cy2_q <= cy_i;
      b_q   <= b_d;
      a1b_q <= a1_q;
      h_q   <= h_d;
    end
  end

  // angle
  assign idx = h_q[31 -: ANGLE_BITS];
  assign r   = idx[RBITS-1:0];
  assign z   = 17'(r) << ZSH;
  assign zc  = ONE_Q16 - z;

  // quarter sine for both the sine and cosine arguments
  always_comb begin
    ws = 18'((34'(us_q) * 34'(zs7_q)) >> 16);
    wc = 18'((34'(uc_q) * 34'(zc7_q)) >> 16);
    if (ws > 18'(ONE_Q16)) ws = 18'(ONE_Q16);
    if (wc > 18'(ONE_Q16)) wc = 18'(ONE_Q16);
    s_d = ws[16:1];
    c_d = wc[16:1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= idx[ANGLE_BITS-1 -: 2];
      for (int i = 1; i < 4; i++) quad_q[i] <= quad_q[i-1];
      zs5_q  <= z;
      zc5_q  <= zc;
      z2s_q  <= 17'((34'(z) * 34'(z)) >> 16);
      z2c_q  <= 17'((34'(zc) * 34'(zc)) >> 16);
      ts_q   <= SIN_C3 - 16'((30'(SIN_C5) * 30'(z2s_q)) >> 16);
      tc_q   <= SIN_C3 - 16'((30'(SIN_C5) * 30'(z2c_q)) >> 16);
      z2s6_q <= z2s_q;
      z2c6_q <= z2c_q;
      zs6_q  <= zs5_q;
      zc6_q  <= zc5_q;
      us_q   <= SIN_C1 - 17'((33'(ts_q) * 33'(z2s6_q)) >> 16);
      uc_q   <= SIN_C1 - 17'((33'(tc_q) * 33'(z2c6_q)) >> 16);
      zs7_q  <= zs6_q;
      zc7_q  <= zc6_q;
      s_q    <= s_d;
      c_q    <= c_d;
    end
  end

  // gradient by quadrant
  assign s17 = signed'({1'b0, s_q});
  assign c17 = signed'({1'b0, c_q});

  always_comb begin
    unique case (quad_q[3])
      2'd0: begin gx_d = c17;  gy_d = s17;  end
      2'd1: begin gx_d = -s17; gy_d = c17;  end
      2'd2: begin gx_d = -c17; gy_d = -s17; end
      default: begin gx_d = s17; gy_d = -c17; end
    endcase
  end

  // hold offsets until the gradient is ready
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ofx_q[0] <= dx_i;
      ofy_q[0] <= dy_i;
      for (int i = 1; i < OFS_DELAY; i++) begin
        ofx_q[i] <= ofx_q[i-1];
        ofy_q[i] <= ofy_q[i-1];
      end
      gx_q  <= gx_d;
      gy_q  <= gy_d;
      px_q  <= 34'(gx_q) * 34'(ofx_q[OFS_DELAY-1]);
      py_q  <= 34'(gy_q) * 34'(ofy_q[OFS_DELAY-1]);
      dot_o <= 35'(px_q) + 35'(py_q);
    end
  end

endmodule

### rtl/pnd_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnd_weight
// Smoothstep weights 3w^2-2w^3 for the x and y fractions, aligned to the
// blend stages of the top level.
// ----------------------------------------------------------------------------
module pnd_weight import pnd_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] fx_i,
  input  logic [15:0] fy_i,
  output logic [16:0] wx_o,
  output logic [16:0] wy_o
);

  logic [15:0] fx_q [FRAC_DELAY];
  logic [15:0] fy_q [FRAC_DELAY];
  logic [15:0] fxs_q, fys_q, x2_q, y2_q;
  logic [16:0] wy_q [WY_DELAY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q[0] <= fx_i;
      fy_q[0] <= fy_i;
      for (int i = 1; i < FRAC_DELAY; i++) begin
        fx_q[i] <= fx_q[i-1];
        fy_q[i] <= fy_q[i-1];
      end
      x2_q  <= 16'((32'(fx_q[FRAC_DELAY-1]) * 32'(fx_q[FRAC_DELAY-1])) >> 16);
      y2_q  <= 16'((32'(fy_q[FRAC_DELAY-1]) * 32'(fy_q[FRAC_DELAY-1])) >> 16);
      fxs_q <= fx_q[FRAC_DELAY-1];
      fys_q <= fy_q[FRAC_DELAY-1];
      wx_o  <= 17'(((34'(196608) - 34'({fxs_q, 1'b0})) * 34'(x2_q)) >> 16);
      wy_q[0] <= 17'(((34'(196608) - 34'({fys_q, 1'b0})) * 34'(y2_q)) >> 16);
      for (int i = 1; i < WY_DELAY; i++) wy_q[i] <= wy_q[i-1];
    end
  end

  assign wy_o = wy_q[WY_DELAY-1];

endmodule

### rtl/perlin_noise_2d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_2d_unit
// 2D hashed gradient noise: Q16.16 point in, saturated Q1.15 value out.
// ----------------------------------------------------------------------------
// channel | signals                              | word
// in      | in_valid_i in_ready_o x_pos_i y_pos_i | one point
// out     | out_valid_o out_ready_i noise_value_o | one noise value
//
// One point per cycle while the output is not stalled; the pipeline runs through the
// corner hash chain (three multiplies), the four-multiply sine and the two blends.
// Reset clears only the stage valid bits.
// A stalled output word holds the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module perlin_noise_2d_unit import pnd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] x_pos_i,
  input  logic signed [31:0] y_pos_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] noise_value_o
);

  logic en;
  logic [PIPE_DEPTH-1:0] v_q;

  logic [FRAC_BITS+23:0] fxw, fyw;
  logic [31:0] x0_q, y0_q, x1_q, y1_q;
  logic [15:0] fx_q, fy_q;
  logic signed [16:0] dx0, dx1, dy0, dy1;

  logic signed [34:0] n00, n10, n01, n11;
  logic [16:0] wx, wy;

  logic signed [35:0] d0_q, d1_q, ix0_q, ix1_q, ix0b_q, ix0c_q;
  logic signed [34:0] n00b_q, n01b_q, n00c_q, n01c_q;
  logic signed [53:0] p0_q, p1_q;
  logic signed [36:0] dy_q;
  logic signed [54:0] py_q;
  logic signed [37:0] vs;
  logic signed [21:0] vf;
  logic signed [15:0] sat_d;

  assign en          = ~v_q[PIPE_DEPTH-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // split into lattice cell and Q16 fraction
  assign fxw = {x_pos_i[FRAC_BITS-1:0], 24'b0} >> FRAC_BITS;
  assign fyw = {y_pos_i[FRAC_BITS-1:0], 24'b0} >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= 32'(x_pos_i >>> FRAC_BITS);
      y0_q <= 32'(y_pos_i >>> FRAC_BITS);
      x1_q <= 32'(x_pos_i >>> FRAC_BITS) + 32'd1;
      y1_q <= 32'(y_pos_i >>> FRAC_BITS) + 32'd1;
      fx_q <= fxw[23:8];
      fy_q <= fyw[23:8];
    end
  end

  assign dx0 = signed'({1'b0, fx_q});
  assign dy0 = signed'({1'b0, fy_q});
  assign dx1 = signed'({1'b1, fx_q});
  assign dy1 = signed'({1'b1, fy_q});

  pnd_corner u_c00 (.clk_i, .en_i(en), .cx_i(x0_q), .cy_i(y0_q),
                    .dx_i(dx0), .dy_i(dy0), .dot_o(n00));
  pnd_corner u_c10 (.clk_i, .en_i(en), .cx_i(x1_q), .cy_i(y0_q),
                    .dx_i(dx1), .dy_i(dy0), .dot_o(n10));
  pnd_corner u_c01 (.clk_i, .en_i(en), .cx_i(x0_q), .cy_i(y1_q),
                    .dx_i(dx0), .dy_i(dy1), .dot_o(n01));
  pnd_corner u_c11 (.clk_i, .en_i(en), .cx_i(x1_q), .cy_i(y1_q),
                    .dx_i(dx1), .dy_i(dy1), .dot_o(n11));

  pnd_weight u_weight (.clk_i, .en_i(en), .fx_i(fx_q), .fy_i(fy_q),
                       .wx_o(wx), .wy_o(wy));

  // final blend along y, floor shifts, saturate
  always_comb begin
    vs = 38'(ix0c_q) + 38'(py_q >>> 16);
    vf = 22'(vs >>> 16);
    if (vf > 22'sd32767)       sat_d = 16'sh7fff;
    else if (vf < -22'sd32768) sat_d = 16'sh8000;
    else                       sat_d = vf[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q   <= 36'(n10) - 36'(n00);
      d1_q   <= 36'(n11) - 36'(n01);
      n00b_q <= n00;
      n01b_q <= n01;
      p0_q   <= 54'(d0_q) * 54'(signed'({1'b0, wx}));
      p1_q   <= 54'(d1_q) * 54'(signed'({1'b0, wx}));
      n00c_q <= n00b_q;
      n01c_q <= n01b_q;
      ix0_q  <= 36'(n00c_q) + 36'(p0_q >>> 16);
      ix1_q  <= 36'(n01c_q) + 36'(p1_q >>> 16);
      dy_q   <= 37'(ix1_q) - 37'(ix0_q);
      ix0b_q <= ix0_q;
      py_q   <= 55'(dy_q) * 55'(signed'({1'b0, wy}));
      ix0c_q <= ix0b_q;
      noise_value_o <= sat_d;
    end
  end

endmodule

### test/perlin_noise_2d_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_noise_2d_unit_test
// Drives points into the noise pipeline with random bursts and output stalls,
// predicts each noise value in place and checks it against the output words.
// ----------------------------------------------------------------------------
module perlin_noise_2d_unit_test;
  import pnd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] x_pos_i = '0;
  logic signed [31:0] y_pos_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] noise_value_o;

  logic signed [15:0] noise_expected_q[$];
  int unsigned        mismatches = 0;
  int unsigned        words_checked = 0;
  int unsigned        points_sent = 0;
  int unsigned        cycle_count = 0;
  int unsigned        hold_off_cycles = 0;
  bit                 stall_random = 1'b1;

  always #4 clk_i = ~clk_i;

  perlin_noise_2d_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .noise_value_o(noise_value_o)
  );

  // ---------------- noise predictor ----------------
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint unsigned sine_q15(longint unsigned z);
    longint unsigned z2, t;
    z2 = (z * z) >> 16;
    t  = (longint'(SIN_C5) * z2) >> 16;
    t  = longint'(SIN_C3) - t;
    t  = (t * z2) >> 16;
    t  = longint'(SIN_C1) - t;
    t  = (t * z) >> 16;
    if (t > 65536) t = 65536;
    return t >> 1;
  endfunction

  function automatic longint gradient_dot(bit [31:0] cx, bit [31:0] cy,
                                          longint ox, longint oy);
    bit [31:0]       a, b, idx, quad, r;
    longint unsigned z;
    longint          s, c, gx, gy;
    a = cx * HASH_M1;
    b = cy ^ {a[15:0], a[31:16]};
    b = b * HASH_M2;
    a = a ^ {b[15:0], b[31:16]};
    a = a * HASH_M3;
    idx  = a >> (32 - ANGLE_BITS);
    quad = idx >> (ANGLE_BITS - 2);
    r    = idx & ((32'd1 << (ANGLE_BITS - 2)) - 1);
    z    = longint'(r) << (16 - (ANGLE_BITS - 2));
    s    = longint'(sine_q15(z));
    c    = longint'(sine_q15(65536 - z));
    case (quad[1:0])
      2'd0: begin gx = c;  gy = s;  end
      2'd1: begin gx = -s; gy = c;  end
      2'd2: begin gx = -c; gy = -s; end
      default: begin gx = s; gy = -c; end
    endcase
    return gx * ox + gy * oy;
  endfunction

  function automatic longint smoothstep_q16(longint w);
    longint w2;
    w2 = (w * w) >> 16;
    return ((3 * 65536 - 2 * w) * w2) >> 16;
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint w);
    return a + floor_shr((b - a) * w, 16);
  endfunction

  function automatic logic signed [15:0] noise_at(bit [31:0] xp, bit [31:0] yp);
    bit [31:0] x0, y0, x1, y1;
    longint    fx, fy, wx, wy, ix0, ix1, v;
    x0 = $signed(xp) >>> FRAC_BITS;
    y0 = $signed(yp) >>> FRAC_BITS;
    x1 = x0 + 1;
    y1 = y0 + 1;
    fx = longint'(xp & ((32'd1 << FRAC_BITS) - 1)) << (16 - FRAC_BITS);
    fy = longint'(yp & ((32'd1 << FRAC_BITS) - 1)) << (16 - FRAC_BITS);
    wx = smoothstep_q16(fx);
    wy = smoothstep_q16(fy);
    ix0 = lerp_q16(gradient_dot(x0, y0, fx, fy),
                   gradient_dot(x1, y0, fx - 65536, fy), wx);
    ix1 = lerp_q16(gradient_dot(x0, y1, fx, fy - 65536),
                   gradient_dot(x1, y1, fx - 65536, fy - 65536), wx);
    v = floor_shr(lerp_q16(ix0, ix1, wy), 16);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // ---------------- sender ----------------
  task automatic send_point(input bit [31:0] xp, input bit [31:0] yp);
    in_valid_i <= 1'b1;
    x_pos_i    <= xp;
    y_pos_i    <= yp;
    noise_expected_q.push_back(noise_at(xp, yp));
    do @(posedge clk_i); while (!in_ready_o);
    points_sent++;
  endtask

  task automatic idle_input(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Burst of random points, with a gap of random length before most bursts.
  task automatic send_bursts(input int unsigned count, input int unsigned mode);
    int unsigned burst;
    bit [31:0]   xp, yp;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
        burst = $urandom_range(1, 20);
      end
      burst--;
      case (mode)
        0: begin xp = $urandom(); yp = $urandom(); end
        1: begin
          xp = {{16{1'b0}}, 16'($urandom())} - 32'h0010_0000 + ($urandom_range(0, 32) << 16);
          yp = {{16{1'b0}}, 16'($urandom())} - 32'h0010_0000 + ($urandom_range(0, 32) << 16);
        end
        default: begin
          xp = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000) ^ 32'($urandom_range(0, 18'h3FFFF));
          yp = $urandom();
        end
      endcase
      send_point(xp, yp);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (noise_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    bit [31:0] corners[8];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0000_8000, 32'hFFFF_0000, 32'h7FFF_0001, 32'h0001_FFFF};
    for (int i = 0; i < 8; i++) send_point(corners[i], corners[(i * 3 + 1) % 8]);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'hAAAA_AAAA, 32'h5555_5555);
    send_point(32'h5555_5555, 32'hAAAA_AAAA);
    send_point(32'h0003_4000, 32'hFFFE_C000);
    in_valid_i <= 1'b0;
  endtask

  task automatic test_random_stream();
    send_bursts(150, 0);
    send_bursts(100, 1);
    send_bursts(60, 2);
  endtask

  // Output held off long enough to fill the pipeline and back up the input.
  task automatic test_backpressure();
    hold_off_cycles = 60;
    send_bursts(60, 0);
  endtask

  task automatic test_drain_then_stream();
    wait_drained();
    send_bursts(60, 1);
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i     <= 1'b0;
    end else if (stall_random) begin
      // mostly ready, with random stalls in a recurring window of the cycle count
      out_ready_i <= (cycle_count % 256 < 200) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (noise_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: noise_value %0d", noise_value_o);
      end else begin
        if (noise_value_o !== noise_expected_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise_value mismatch: expected %0d, got %0d",
                     noise_expected_q[0], noise_value_o);
        end
        void'(noise_expected_q.pop_front());
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("perlin_noise_2d_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_stream();
    test_backpressure();
    test_drain_then_stream();
    wait_drained();
    repeat (PIPE_DEPTH * 3) @(posedge clk_i);
    $display("Sent %0d points, checked %0d noise words: corners, edge wraps, random,",
             points_sent, words_checked);
    $display("near-origin and extreme coordinates under bursts and output stalls.");
    if (mismatches == 0 && noise_expected_q.size() == 0)
      $display("perlin_noise_2d_unit_test OK");
    else
      $display("perlin_noise_2d_unit_test NOT OK");
    $finish;
  end

endmodule

### filelist.f
rtl/pnd_pkg.sv
rtl/pnd_corner.sv
rtl/pnd_weight.sv
rtl/perlin_noise_2d_unit.sv
test/perlin_noise_2d_unit_test.sv
